// ----- design/dedf_pkg.sv -----
package dedf_pkg;

    typedef enum logic [3:0] {
        KIND_SIZE       = 4'd0,
        KIND_BOARD      = 4'd1,
        KIND_PATTERN    = 4'd2,
        KIND_CHANNEL    = 4'd3,
        KIND_COUNTER    = 4'd4,
        KIND_TIME_TAG   = 4'd5,
        KIND_OFFSET     = 4'd6,
        KIND_START_CELL = 4'd7,
        KIND_PAYLOAD    = 4'd8,
        KIND_IGNORED    = 4'd9
    } word_kind_t;

    // header_position value that marks the payload phase
    localparam logic [3:0] HDR_POS_PAYLOAD = 4'd8;

    localparam logic [3:0]  HDR_WORDS_WIDE   = 4'd8;
    localparam logic [3:0]  HDR_WORDS_NARROW = 4'd6;
    localparam logic [31:0] HDR_BYTES_WIDE   = 32'd32;
    localparam logic [31:0] HDR_BYTES_NARROW = 32'd24;

    // rollover period: 2^30 in wide mode, 2^31 in narrow mode
    localparam int ROLL_SHIFT_WIDE   = 30;
    localparam int ROLL_SHIFT_NARROW = 31;

endpackage

// ----- design/digitizer_event_deframer.sv -----
// Channel   | Direction | Handshake              | Payload
// ----------+-----------+------------------------+-----------------------------------------
// input     | in        | in_valid / in_ready    | stream_word
// output    | out       | out_valid / out_ready  | word_kind, word_value, first_sample,
//           |           |                        | second_sample, extended_tag,
//           |           |                        | last_of_event, sequence_break, size_error
// config    | in        | cfg_wr_en (no wait)    | cfg_wr_data -> wide_mode
//
// One word per clock unless the output stalls; words pass input, then result register.
// Deframing state and the time-tag extension update as a word moves from the input
// register to the result register; the tag path is two 64-bit adds and a compare.
// While the output stalls, the input register still takes one more word.
// rst_n clears all control state; wide_mode resets to narrow mode.
module digitizer_event_deframer
    import dedf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] stream_word,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  word_kind,
    output logic [31:0] word_value,
    output logic [15:0] first_sample,
    output logic [15:0] second_sample,
    output logic [63:0] extended_tag,
    output logic        last_of_event,
    output logic        sequence_break,
    output logic        size_error
);

    logic        wide_mode_reg;

    logic        in_valid_reg;
    logic [31:0] word_reg;

    logic [3:0]  hdr_pos_reg,    hdr_pos_next;
    logic [29:0] payload_left_reg, payload_left_next;
    logic [31:0] roll_cnt_reg,   roll_cnt_next;
    logic [63:0] last_tag_reg,   last_tag_next;
    logic [31:0] prev_cnt_reg,   prev_cnt_next;
    logic        break_pend_reg, break_pend_next;
    logic        halted_reg,     halted_next;

    logic        out_valid_reg;
    word_kind_t  kind_reg,       kind_next;
    logic [31:0] value_reg;
    logic [15:0] first_reg,      first_next;
    logic [15:0] second_reg,     second_next;
    logic [63:0] tag_out_reg,    tag_out_next;
    logic        last_reg,       last_next;
    logic        seq_brk_reg,    seq_brk_next;
    logic        size_err_reg,   size_err_next;

    logic        in_take;
    logic        advance;

    logic [3:0]  hdr_words;
    logic [31:0] hdr_bytes;
    logic [63:0] roll_base;
    logic [63:0] roll_base_inc;
    logic [63:0] tag_plain;
    logic [63:0] tag_rolled;
    logic        counter_brk;
    logic [29:0] payload_dec;
    logic [31:0] size_diff;
    logic        end_event;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || !out_valid_reg || out_ready;
    assign in_take  = in_valid && in_ready;

    assign hdr_words = wide_mode_reg ? HDR_WORDS_WIDE : HDR_WORDS_NARROW;
    assign hdr_bytes = wide_mode_reg ? HDR_BYTES_WIDE : HDR_BYTES_NARROW;

    // rollover_count * R and (rollover_count + 1) * R, both as shifts
    assign roll_base     = wide_mode_reg ? ({32'd0, roll_cnt_reg} << ROLL_SHIFT_WIDE)
                                         : ({32'd0, roll_cnt_reg} << ROLL_SHIFT_NARROW);
    assign roll_base_inc = wide_mode_reg ? ({31'd0, {1'b0, roll_cnt_reg} + 33'd1} << ROLL_SHIFT_WIDE)
                                         : ({31'd0, {1'b0, roll_cnt_reg} + 33'd1} << ROLL_SHIFT_NARROW);
    assign tag_plain  = {32'd0, word_reg} + roll_base;
    assign tag_rolled = {32'd0, word_reg} + roll_base_inc;

    // +1 is not wrapped: a previous count of all ones breaks on any counter
    assign counter_brk = (prev_cnt_reg != 32'd0) &&
                         ({1'b0, word_reg} != ({1'b0, prev_cnt_reg} + 33'd1));

    assign payload_dec = (payload_left_reg != 30'd0) ? payload_left_reg - 30'd1 : 30'd0;
    assign size_diff   = word_reg - hdr_bytes;

    always_comb
    begin
        hdr_pos_next      = hdr_pos_reg;
        payload_left_next = payload_left_reg;
        roll_cnt_next     = roll_cnt_reg;
        last_tag_next     = last_tag_reg;
        prev_cnt_next     = prev_cnt_reg;
        break_pend_next   = break_pend_reg;
        halted_next       = halted_reg;

        kind_next     = KIND_IGNORED;
        first_next    = 16'd0;
        second_next   = 16'd0;
        tag_out_next  = last_tag_reg;
        last_next     = 1'b0;
        seq_brk_next  = 1'b0;
        size_err_next = 1'b0;
        end_event     = 1'b0;

        if (halted_reg)
        begin
            kind_next = KIND_IGNORED;
        end
        else if (hdr_pos_reg == HDR_POS_PAYLOAD)
        begin
            kind_next = KIND_PAYLOAD;
            if (!wide_mode_reg)
            begin
                first_next  = word_reg[15:0];
                second_next = word_reg[31:16];
            end
            payload_left_next = payload_dec;
            end_event         = (payload_dec == 30'd0);
        end
        else
        begin
            kind_next = word_kind_t'(hdr_pos_reg);
            unique case (hdr_pos_reg)
                4'd0:
                begin
                    if (word_reg < hdr_bytes)
                    begin
                        size_err_next     = 1'b1;
                        payload_left_next = 30'd0;
                    end
                    else
                    begin
                        payload_left_next = size_diff[31:2];
                    end
                end
                4'd4:
                begin
                    if (counter_brk)
                    begin
                        seq_brk_next    = 1'b1;
                        break_pend_next = 1'b1;
                    end
                    else
                    begin
                        prev_cnt_next = word_reg;
                    end
                end
                4'd5:
                begin
                    if (tag_plain < last_tag_reg)
                    begin
                        roll_cnt_next = roll_cnt_reg + 32'd1;
                        last_tag_next = tag_rolled;
                        tag_out_next  = tag_rolled;
                    end
                    else
                    begin
                        last_tag_next = tag_plain;
                        tag_out_next  = tag_plain;
                    end
                end
                default:
                begin
                end
            endcase

            if ({1'b0, hdr_pos_reg} + 5'd1 >= {1'b0, hdr_words})
            begin
                if (payload_left_next == 30'd0)
                    end_event = 1'b1;
                else
                    hdr_pos_next = HDR_POS_PAYLOAD;
            end
            else
            begin
                hdr_pos_next = hdr_pos_reg + 4'd1;
            end
        end

        if (end_event)
        begin
            last_next    = 1'b1;
            hdr_pos_next = 4'd0;
            if (break_pend_next)
            begin
                halted_next     = 1'b1;
                break_pend_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wide_mode_reg    <= 1'b0;
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            hdr_pos_reg      <= 4'd0;
            payload_left_reg <= 30'd0;
            roll_cnt_reg     <= 32'd0;
            last_tag_reg     <= 64'd0;
            prev_cnt_reg     <= 32'd0;
            break_pend_reg   <= 1'b0;
            halted_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                wide_mode_reg <= cfg_wr_data;

            if (in_take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (advance)
            begin
                hdr_pos_reg      <= hdr_pos_next;
                payload_left_reg <= payload_left_next;
                roll_cnt_reg     <= roll_cnt_next;
                last_tag_reg     <= last_tag_next;
                prev_cnt_reg     <= prev_cnt_next;
                break_pend_reg   <= break_pend_next;
                halted_reg       <= halted_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            word_reg <= stream_word;
        if (advance)
        begin
            kind_reg     <= kind_next;
            value_reg    <= word_reg;
            first_reg    <= first_next;
            second_reg   <= second_next;
            tag_out_reg  <= tag_out_next;
            last_reg     <= last_next;
            seq_brk_reg  <= seq_brk_next;
            size_err_reg <= size_err_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign word_kind      = kind_reg;
    assign word_value     = value_reg;
    assign first_sample   = first_reg;
    assign second_sample  = second_reg;
    assign extended_tag   = tag_out_reg;
    assign last_of_event  = last_reg;
    assign sequence_break = seq_brk_reg;
    assign size_error     = size_err_reg;

    a_break_on_counter: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && seq_brk_reg |-> kind_reg == KIND_COUNTER)
        else $error("sequence break flagged on a non-counter word");

    a_size_err_on_size: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && size_err_reg |-> kind_reg == KIND_SIZE)
        else $error("size error flagged on a non-size word");

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halt released without reset");

    a_hdr_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_pos_reg <= HDR_POS_PAYLOAD)
        else $error("header position out of range");

    a_samples_on_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (first_reg != 16'd0 || second_reg != 16'd0)
        |-> kind_reg == KIND_PAYLOAD)
        else $error("samples on a non-payload word");

endmodule

// ----- test/tb_digitizer_event_deframer.sv -----
`timescale 1ns / 1ps

module tb_digitizer_event_deframer;
    import dedf_pkg::*;

    localparam int STALL_LIMIT = 2000;

    typedef struct {
        word_kind_t  kind;
        logic [31:0] value;
        logic [15:0] lo;
        logic [15:0] hi;
        logic [63:0] tag;
        bit          last;
        bit          brk;
        bit          serr;
    } labelled_word_t;

    typedef struct {
        bit          mode;
        logic [31:0] word;
        bit          typed;
        word_kind_t  kind;
        logic [63:0] tag;
        bit          last;
        bit          serr;
    } directed_row_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_wr_data = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [31:0] stream_word = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [3:0]  word_kind;
    logic [31:0] word_value;
    logic [15:0] first_sample;
    logic [15:0] second_sample;
    logic [63:0] extended_tag;
    logic        last_of_event;
    logic        sequence_break;
    logic        size_error;

    digitizer_event_deframer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .stream_word   (stream_word),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .word_kind     (word_kind),
        .word_value    (word_value),
        .first_sample  (first_sample),
        .second_sample (second_sample),
        .extended_tag  (extended_tag),
        .last_of_event (last_of_event),
        .sequence_break(sequence_break),
        .size_error    (size_error)
    );

    // deframer state as predicted
    bit          wide;
    logic [3:0]  hdr_pos;
    logic [29:0] words_left;
    logic [31:0] rollovers;
    logic [63:0] tag_hist;
    logic [31:0] last_count;
    bit          break_seen;
    bit          stopped;

    labelled_word_t labelled_words_due[$];
    directed_row_t  directed_rows[23];

    int  errors;
    int  words_sent;
    int  words_checked;
    int  mode_writes;
    int  size_errors;
    int  idle_cycles;
    int  burst_left;
    int  stall_run;
    int  ready_mode;
    bit  want_break;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic void close_event();
        hdr_pos = '0;
        if (break_seen)
        begin
            stopped = 1'b1;
            break_seen = 1'b0;
        end
    endfunction

    function automatic void queue_expected(input labelled_word_t r);
        labelled_words_due.insert(labelled_words_due.size(), r);
    endfunction

    function automatic labelled_word_t deframe_word(input logic [31:0] w);
        labelled_word_t r;
        logic [3:0]  hdr_words;
        logic [31:0] hdr_bytes;
        logic [63:0] period;
        logic [63:0] ext;
        hdr_words = wide ? HDR_WORDS_WIDE : HDR_WORDS_NARROW;
        hdr_bytes = wide ? HDR_BYTES_WIDE : HDR_BYTES_NARROW;
        period = 64'd1 << (wide ? ROLL_SHIFT_WIDE : ROLL_SHIFT_NARROW);
        r.kind = KIND_IGNORED;
        r.value = w;
        r.lo = '0;
        r.hi = '0;
        r.tag = tag_hist;
        r.last = 1'b0;
        r.brk = 1'b0;
        r.serr = 1'b0;
        if (stopped)
            return r;
        if (hdr_pos == HDR_POS_PAYLOAD)
        begin
            r.kind = KIND_PAYLOAD;
            if (!wide)
            begin
                r.lo = w[15:0];
                r.hi = w[31:16];
            end
            if (words_left != 0)
                words_left--;
            if (words_left == 0)
            begin
                r.last = 1'b1;
                close_event();
            end
            return r;
        end
        r.kind = word_kind_t'(hdr_pos);
        case (r.kind)
            KIND_SIZE:
            begin
                if (w < hdr_bytes)
                begin
                    r.serr = 1'b1;
                    words_left = '0;
                end
                else
                    words_left = 30'((w - hdr_bytes) >> 2);
            end
            KIND_COUNTER:
            begin
                // +1 is taken without wrap
                if (last_count != 0 && {1'b0, w} != {1'b0, last_count} + 33'd1)
                begin
                    r.brk = 1'b1;
                    break_seen = 1'b1;
                end
                else
                    last_count = w;
            end
            KIND_TIME_TAG:
            begin
                ext = {32'd0, w} + {32'd0, rollovers} * period;
                if (ext < tag_hist)
                begin
                    rollovers++;
                    ext += period;
                end
                tag_hist = ext;
                r.tag = ext;
            end
            default: ;
        endcase
        // header length follows the mode in force at this word
        if (hdr_pos + 4'd1 >= hdr_words)
        begin
            if (words_left == 0)
            begin
                r.last = 1'b1;
                close_event();
            end
            else
                hdr_pos = HDR_POS_PAYLOAD;
        end
        else
            hdr_pos++;
        return r;
    endfunction

    // mostly well-formed events; noise only where it cannot stall or halt the block
    function automatic logic [31:0] next_stream_word();
        logic [31:0] hdr_bytes;
        logic [63:0] near;
        int pick;
        hdr_bytes = wide ? HDR_BYTES_WIDE : HDR_BYTES_NARROW;
        pick = $urandom_range(0, 15);
        if (stopped || hdr_pos == HDR_POS_PAYLOAD)
            return (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom;
        case (word_kind_t'(hdr_pos))
            KIND_SIZE:
            begin
                if (pick == 0)
                    return $urandom_range(0, hdr_bytes - 1);
                if (pick == 1)
                    return hdr_bytes + 4 * $urandom_range(20, 60) + $urandom_range(0, 3);
                return hdr_bytes + 4 * $urandom_range(0, 6) + $urandom_range(0, 3);
            end
            KIND_COUNTER:
            begin
                if (want_break)
                    return last_count + 32'd2;
                return (last_count == 0) ? $urandom_range(1, 1000) : last_count + 32'd1;
            end
            KIND_TIME_TAG:
            begin
                // land on or just above the last tag now and then
                near = tag_hist - {32'd0, rollovers} *
                       (64'd1 << (wide ? ROLL_SHIFT_WIDE : ROLL_SHIFT_NARROW));
                if (pick < 4 && near[63:32] == 0)
                    return near[31:0] + $urandom_range(0, 3);
                return $urandom;
            end
            default:
                return (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom;
        endcase
    endfunction

    task automatic send_word(input logic [31:0] w, output labelled_word_t predicted);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        else
            burst_left--;
        in_valid <= 1'b1;
        stream_word <= w;
        do
            @(posedge clk);
        while (!in_ready);
        if (!stopped)
            words_sent++;
        predicted = deframe_word(w);
        if (predicted.serr)
            size_errors++;
    endtask

    task automatic send_next_word();
        labelled_word_t p;
        send_word(next_stream_word(), p);
        queue_expected(p);
    endtask

    // called in the step of the last handshake; pipeline is drained before the write
    task automatic write_mode(input bit m);
        in_valid <= 1'b0;
        while (labelled_words_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= m;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        wide = m;
        mode_writes++;
    endtask

    task automatic report(input string field, input logic [63:0] exp_v, input logic [63:0] act_v);
        $error("%s: expected 0x%0h, got 0x%0h", field, exp_v, act_v);
        errors++;
    endtask

    // receiver stall pattern, independent of the sender
    always @(posedge clk)
    begin
        if ($urandom_range(0, 99) == 0)
            ready_mode = $urandom_range(0, 2);
        if (stall_run != 0)
        begin
            out_ready <= 1'b0;
            stall_run--;
        end
        else
        begin
            case (ready_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= $urandom_range(0, 1);
                default:
                begin
                    if ($urandom_range(0, 15) == 0)
                    begin
                        stall_run = $urandom_range(1, 8);
                        out_ready <= 1'b0;
                    end
                    else
                        out_ready <= 1'b1;
                end
            endcase
        end
    end

    always @(posedge clk)
    begin
        labelled_word_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (labelled_words_due.size() == 0)
            begin
                $error("result transaction with nothing expected: word_value 0x%0h", word_value);
                errors++;
            end
            else
            begin
                e = labelled_words_due.pop_front();
                words_checked++;
                if (word_kind !== e.kind)              report("word_kind", e.kind, word_kind);
                if (word_value !== e.value)            report("word_value", e.value, word_value);
                if (first_sample !== e.lo)             report("first_sample", e.lo, first_sample);
                if (second_sample !== e.hi)            report("second_sample", e.hi, second_sample);
                if (extended_tag !== e.tag)            report("extended_tag", e.tag, extended_tag);
                if (last_of_event !== e.last)          report("last_of_event", e.last, last_of_event);
                if (sequence_break !== e.brk)          report("sequence_break", e.brk, sequence_break);
                if (size_error !== e.serr)             report("size_error", e.serr, size_error);
            end
        end
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout: %0d results still due", labelled_words_due.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        labelled_word_t p;
        int phase_len;
        wide = 1'b0;
        hdr_pos = '0;
        words_left = '0;
        rollovers = '0;
        tag_hist = '0;
        last_count = '0;
        break_seen = 1'b0;
        stopped = 1'b0;
        want_break = 1'b0;
        errors = 0;
        words_sent = 0;
        words_checked = 0;
        mode_writes = 0;
        size_errors = 0;
        idle_cycles = 0;
        burst_left = 0;
        stall_run = 0;
        ready_mode = 0;

        directed_rows = '{
            // after reset, narrow: size zero is a size error, event ends at the header
            '{1'b0, 32'h0000_0000, 1'b1, KIND_SIZE,       64'h0,           1'b0, 1'b1},
            '{1'b0, 32'hFFFF_FFFF, 1'b1, KIND_BOARD,      64'h0,           1'b0, 1'b0},
            '{1'b0, 32'h0000_0000, 1'b1, KIND_PATTERN,    64'h0,           1'b0, 1'b0},
            '{1'b0, 32'hFFFF_FFFF, 1'b1, KIND_CHANNEL,    64'h0,           1'b0, 1'b0},
            '{1'b0, 32'h0000_0000, 1'b1, KIND_COUNTER,    64'h0,           1'b0, 1'b0},
            '{1'b0, 32'hFFFF_FFFF, 1'b1, KIND_TIME_TAG,   64'hFFFF_FFFF,   1'b1, 1'b0},
            // narrow event with two payload words, tag rolls over
            '{1'b0, 32'd32,        1'b0, KIND_SIZE,       64'h0,           1'b0, 1'b0},
            '{1'b0, 32'h1234_5678, 1'b0, KIND_SIZE,       64'h0,           1'b0, 1'b0},
            '{1'b0, 32'h0000_00FF, 1'b0, KIND_SIZE,       64'h0,           1'b0, 1'b0},
            '{1'b0, 32'h8000_0001, 1'b0, KIND_SIZE,       64'h0,           1'b0, 1'b0},
            '{1'b0, 32'd1,         1'b0, KIND_SIZE,       64'h0,           1'b0, 1'b0},
            '{1'b0, 32'h0000_0010, 1'b0, KIND_SIZE,       64'h0,           1'b0, 1'b0},
            '{1'b0, 32'hFFFF_0000, 1'b0, KIND_SIZE,       64'h0,           1'b0, 1'b0},
            '{1'b0, 32'h0000_FFFF, 1'b0, KIND_SIZE,       64'h0,           1'b0, 1'b0},
            // wide event with empty payload
            '{1'b1, 32'd32,        1'b0, KIND_SIZE,       64'h0,           1'b0, 1'b0},
            '{1'b1, 32'hDEAD_BEEF, 1'b0, KIND_SIZE,       64'h0,           1'b0, 1'b0},
            '{1'b1, 32'h0000_0000, 1'b0, KIND_SIZE,       64'h0,           1'b0, 1'b0},
            '{1'b1, 32'h7FFF_FFFF, 1'b0, KIND_SIZE,       64'h0,           1'b0, 1'b0},
            '{1'b1, 32'd2,         1'b0, KIND_SIZE,       64'h0,           1'b0, 1'b0},
            '{1'b1, 32'hFFFF_FFFF, 1'b0, KIND_SIZE,       64'h0,           1'b0, 1'b0},
            '{1'b1, 32'h5A5A_5A5A, 1'b0, KIND_SIZE,       64'h0,           1'b0, 1'b0},
            '{1'b1, 32'hA5A5_A5A5, 1'b0, KIND_SIZE,       64'h0,           1'b0, 1'b0},
            // one byte short of the wide header
            '{1'b1, 32'd31,        1'b1, KIND_SIZE,       64'h1_3FFF_FFFF, 1'b0, 1'b1}
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].mode != wide)
                write_mode(directed_rows[i].mode);
            send_word(directed_rows[i].word, p);
            if (directed_rows[i].typed)
            begin
                p.kind = directed_rows[i].kind;
                p.value = directed_rows[i].word;
                p.lo = '0;
                p.hi = '0;
                p.tag = directed_rows[i].tag;
                p.last = directed_rows[i].last;
                p.brk = 1'b0;
                p.serr = directed_rows[i].serr;
            end
            queue_expected(p);
        end

        // random phases; mode writes land anywhere in an event
        while (words_sent < 640)
        begin
            phase_len = $urandom_range(30, 140);
            repeat (phase_len) send_next_word();
            write_mode($urandom_range(0, 1));
        end

        // finish the open event, then one with a counter break, then the halted stream
        while (hdr_pos != 0)
            send_next_word();
        want_break = 1'b1;
        while (!stopped)
            send_next_word();
        repeat (12) send_next_word();
        in_valid <= 1'b0;

        while (labelled_words_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("%0d stream words deframed, %0d results checked, %0d mode writes",
                 words_sent, words_checked, mode_writes);
        $display("%0d size errors, %0d tag rollovers, halted on counter break: %0d",
                 size_errors, rollovers, stopped);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
design/dedf_pkg.sv
design/digitizer_event_deframer.sv
test/tb_digitizer_event_deframer.sv
